// ----- sv/vn_pkg.sv -----
// Package: widths and pipeline record types for the vector normalize unit.
`timescale 1ns / 1ps
package vn_pkg;

  localparam int COMP_W     = 24;               // Q12.12 input component
  localparam int MAG_W      = COMP_W;           // magnitude holds 2^(COMP_W-1)
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;         // four squares, kept even
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 1;
  localparam int FRAC_SHIFT = 30;
  localparam int QUO_W      = FRAC_SHIFT + 1;   // quotient never exceeds 2^30
  localparam int DIV_STEPS  = QUO_W;
  localparam int OUT_W      = 32;
  localparam int LANES      = 4;

  typedef logic [MAG_W-1:0] mag_t;

  // state carried through the square root chain
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
    mag_t [LANES-1:0]  mag;
    logic [LANES-1:0]  neg;
  } sqrt_t;

  // state carried through the divider chain, four lanes side by side
  typedef struct packed {
    logic [LANES-1:0][ROOT_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0]  quo;
    logic [LANES-1:0]             nxt;
    logic [ROOT_W-1:0]            len;
    logic [LANES-1:0]             neg;
  } div_t;

endpackage

// ----- sv/vn_if.sv -----
// Request and result channel interfaces for the vector normalize unit.
`timescale 1ns / 1ps
interface vn_req_if import vn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               components;
  logic signed [COMP_W-1:0] x_in;
  logic signed [COMP_W-1:0] y_in;
  logic signed [COMP_W-1:0] z_in;
  logic signed [COMP_W-1:0] w_in;

  modport source (output valid, components, x_in, y_in, z_in, w_in, input ready);
  modport sink   (input valid, components, x_in, y_in, z_in, w_in, output ready);
endinterface

interface vn_rsp_if import vn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] x_out;
  logic signed [OUT_W-1:0] y_out;
  logic signed [OUT_W-1:0] z_out;
  logic signed [OUT_W-1:0] w_out;
  logic                    zero_length;

  modport source (output valid, x_out, y_out, z_out, w_out, zero_length, input ready);
  modport sink   (input valid, x_out, y_out, z_out, w_out, zero_length, output ready);
endinterface

// ----- sv/vn_sqrt_cell.sv -----
// One square root cell: resolves one root bit from two radicand bits.
`timescale 1ns / 1ps
module vn_sqrt_cell import vn_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  sqrt_t                 cell_d, cell_q;
  logic [REM_W+1:0]      rem_sh;
  logic [ROOT_W+1:0]     trial;

  always_comb begin
    rem_sh = {cell_i.rem, cell_i.rad[SUM_W-1 -: 2]};
    trial  = {cell_i.root, 2'b01};
    cell_d = cell_i;
    cell_d.rad = {cell_i.rad[SUM_W-3:0], 2'b00};
    if ({1'b0, rem_sh} >= {1'b0, trial}) begin
      cell_d.rem  = REM_W'(rem_sh - (REM_W+2)'(trial));
      cell_d.root = {cell_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_d.rem  = rem_sh[REM_W-1:0];
      cell_d.root = {cell_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ----- sv/vn_div_cell.sv -----
// One divider cell: resolves one quotient bit in each of the four lanes.
`timescale 1ns / 1ps
module vn_div_cell import vn_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t cell_i,
  output div_t cell_o
);

  div_t cell_d, cell_q;
  logic [LANES-1:0][ROOT_W:0] rem_sh;

  always_comb begin
    cell_d     = cell_i;
    cell_d.nxt = '0;   // dividend bits below the first are zero
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l] = {cell_i.rem[l], cell_i.nxt[l]};
      if (rem_sh[l] >= {1'b0, cell_i.len}) begin
        cell_d.rem[l] = ROOT_W'(rem_sh[l] - {1'b0, cell_i.len});
        cell_d.quo[l] = {cell_i.quo[l][QUO_W-2:0], 1'b1};
      end else begin
        cell_d.rem[l] = rem_sh[l][ROOT_W-1:0];
        cell_d.quo[l] = {cell_i.quo[l][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ----- sv/vector_normalize_unit.sv -----
// Top level: fixed-point 2/3/4-component vector normalization pipeline.
// Pipeline: 3 front stages, 25 square root cells, 31 divider cells, 1 output register.
// Throughput: one request per cycle; the whole chain advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset: rst_ni asynchronous, clears only the stage valid bits.
`timescale 1ns / 1ps
module vector_normalize_unit import vn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  vn_req_if.sink   req_i,
  vn_rsp_if.source rsp_o
);

  localparam int NSTG = 3 + SQRT_STEPS + DIV_STEPS;

  logic                      en;
  logic [NSTG-1:0]           vld_q;
  logic                      out_vld_q;

  // front stages
  mag_t [LANES-1:0]          mag0_q;
  logic [LANES-1:0]          neg0_q;
  logic [LANES-1:0][SQ_W-1:0] sq1_q;
  mag_t [LANES-1:0]          mag1_q;
  logic [LANES-1:0]          neg1_q;
  sqrt_t                     sqrt_in;
  sqrt_t                     sqrt_c [SQRT_STEPS+1];
  div_t                      div_c  [DIV_STEPS+1];
  logic [2:0]                cnt;
  logic signed [COMP_W-1:0]  comp [LANES];
  logic [LANES-1:0]          act;

  // output register
  logic [LANES-1:0][OUT_W-1:0] res_d, res_q;
  logic                        zl_d, zl_q;

  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  always_comb begin
    cnt     = req_i.components;
    comp[0] = req_i.x_in;
    comp[1] = req_i.y_in;
    comp[2] = req_i.z_in;
    comp[3] = req_i.w_in;
    act     = {cnt >= 3'd4, cnt >= 3'd3, 2'b11};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        neg0_q[l] <= act[l] & comp[l][COMP_W-1];
        mag0_q[l] <= !act[l] ? '0 :
                     comp[l][COMP_W-1] ? MAG_W'(-comp[l]) : MAG_W'(comp[l]);
        sq1_q[l]  <= SQ_W'(mag0_q[l] * mag0_q[l]);
      end
      mag1_q <= mag0_q;
      neg1_q <= neg0_q;
      sqrt_in.rad <= SUM_W'(sq1_q[0]) + SUM_W'(sq1_q[1])
                   + SUM_W'(sq1_q[2]) + SUM_W'(sq1_q[3]);
      sqrt_in.mag <= mag1_q;
      sqrt_in.neg <= neg1_q;
      sqrt_in.rem  <= '0;
      sqrt_in.root <= '0;
    end
  end

  assign sqrt_c[0] = sqrt_in;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .cell_i(sqrt_c[s]),
      .cell_o(sqrt_c[s+1])
    );
  end

  // divider seed: dividend is mag << 30, whose top part is mag >> 1
  always_comb begin
    div_c[0]     = '0;
    div_c[0].len = sqrt_c[SQRT_STEPS].root;
    div_c[0].neg = sqrt_c[SQRT_STEPS].neg;
    for (int l = 0; l < LANES; l++) begin
      div_c[0].rem[l] = ROOT_W'(sqrt_c[SQRT_STEPS].mag[l] >> 1);
      div_c[0].nxt[l] = sqrt_c[SQRT_STEPS].mag[l][0];
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    vn_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .cell_i(div_c[s]),
      .cell_o(div_c[s+1])
    );
  end

  always_comb begin
    zl_d = (div_c[DIV_STEPS].len == '0);
    for (int l = 0; l < LANES; l++) begin
      if (zl_d)                      res_d[l] = '0;
      else if (div_c[DIV_STEPS].neg[l]) res_d[l] = -OUT_W'(div_c[DIV_STEPS].quo[l]);
      else                           res_d[l] = OUT_W'(div_c[DIV_STEPS].quo[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTG-2:0], req_i.valid};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      zl_q  <= zl_d;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.x_out       = res_q[0];
  assign rsp_o.y_out       = res_q[1];
  assign rsp_o.z_out       = res_q[2];
  assign rsp_o.w_out       = res_q[3];
  assign rsp_o.zero_length = zl_q;

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.zero_length |->
      rsp_o.x_out == '0 && rsp_o.y_out == '0 && rsp_o.z_out == '0 && rsp_o.w_out == '0)
    else $error("zero length result with nonzero component");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[NSTG-1] |=> out_vld_q)
    else $error("last stage request lost");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> res_q[0] != {1'b1, {(OUT_W-1){1'b0}}})
    else $error("component out of unit range");

endmodule

// ----- tb/sv/vn_checker.sv -----
// Checker: predicts normalized vectors from accepted requests and compares results.
`timescale 1ns / 1ps
module vn_checker import vn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  vn_req_if.sink req_mon,
  vn_rsp_if.sink rsp_mon,
  output int    fail_cnt_o,
  output int    pending_o
);

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] w;
    logic                    zl;
  } unit_vec_t;

  unit_vec_t unit_q[$];
  int        fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = unit_q.size();

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic unit_vec_t normalize(logic [2:0] cnt_raw,
                                          logic signed [COMP_W-1:0] cx,
                                          logic signed [COMP_W-1:0] cy,
                                          logic signed [COMP_W-1:0] cz,
                                          logic signed [COMP_W-1:0] cw);
    int unsigned cnt;
    logic signed [63:0] comp [4];
    logic [63:0] mag [4];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    unit_vec_t r;
    cnt = (cnt_raw < 2) ? 2 : (cnt_raw > 4) ? 4 : cnt_raw;
    comp[0] = cx;
    comp[1] = cy;
    comp[2] = (cnt >= 3) ? 64'(cz) : 64'sd0;
    comp[3] = (cnt == 4) ? 64'(cw) : 64'sd0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
      sum    = sum + mag[i] * mag[i];    // 24-bit inputs cannot overflow 64 bits
    end
    len = floor_sqrt(sum);
    r = '0;
    if (len == 0) begin
      r.zl = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = (mag[i] << FRAC_SHIFT) / len;
      if (comp[i] < 0) q = -q;
      case (i)
        0: r.x = q[31:0];
        1: r.y = q[31:0];
        2: r.z = q[31:0];
        default: r.w = q[31:0];
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    unit_vec_t exp_v;
    unit_vec_t got;
    if (!rst_ni) begin
      fail_cnt <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        unit_q.push_back(normalize(req_mon.components, req_mon.x_in, req_mon.y_in,
                                   req_mon.z_in, req_mon.w_in));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.x_out, rsp_mon.y_out, rsp_mon.z_out, rsp_mon.w_out,
                rsp_mon.zero_length};
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_v = unit_q.pop_front();
          if (got !== exp_v) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d zl=%b",
                     $time, exp_v.x, exp_v.y, exp_v.z, exp_v.w, exp_v.zl);
            $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d zl=%b",
                     $time, got.x, got.y, got.z, got.w, got.zl);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_vector_normalize_unit.sv -----
// Testbench top: request stimulus, result stalls and final verdict.
`timescale 1ns / 1ps
module tb_vector_normalize_unit;
  import vn_pkg::*;

  localparam int N_RANDOM  = 900;
  localparam int IDLE_MAX  = 2000;
  localparam int LATENCY   = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt;
  int   pending;
  int   idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  vn_req_if req_if ();
  vn_rsp_if rsp_if ();

  vector_normalize_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if));

  vn_checker u_checker (.clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_if), .rsp_mon(rsp_if),
                        .fail_cnt_o(fail_cnt), .pending_o(pending));

  localparam logic signed [COMP_W-1:0] CMAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] CMIN = {1'b1, {(COMP_W-1){1'b0}}};

  initial begin
    req_if.valid = 1'b0;
    req_if.components = 3'd2;
    req_if.x_in = '0;
    req_if.y_in = '0;
    req_if.z_in = '0;
    req_if.w_in = '0;
    rsp_if.ready = 1'b0;
  end

  // result side: random stall lengths, with quiet stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  function automatic logic signed [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return COMP_W'($signed(COMP_W'($urandom_range(0, 7))) - 4);
      3: return COMP_W'(COMP_W'($urandom_range(0, 4095)) - 2048);
      default: return COMP_W'($urandom());
    endcase
  endfunction

  task automatic send(logic [2:0] cnt, logic signed [COMP_W-1:0] x,
                      logic signed [COMP_W-1:0] y, logic signed [COMP_W-1:0] z,
                      logic signed [COMP_W-1:0] w, int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.components <= cnt;
    req_if.x_in       <= x;
    req_if.y_in       <= y;
    req_if.z_in       <= z;
    req_if.w_in       <= w;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
  endtask

  initial begin
    int gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero length, extremes, each component count, inactive fields set
    send(3'd2, '0, '0, CMAX, CMIN, 0);
    send(3'd4, '0, '0, '0, '0, 0);
    send(3'd0, CMAX, CMAX, CMIN, CMIN, 0);
    send(3'd1, CMIN, '0, CMAX, CMAX, 0);
    send(3'd2, CMIN, CMIN, CMAX, CMAX, 0);
    send(3'd3, CMIN, CMIN, CMIN, CMAX, 0);
    send(3'd4, CMIN, CMIN, CMIN, CMIN, 0);
    send(3'd4, CMAX, CMAX, CMAX, CMAX, 0);
    send(3'd5, CMAX, CMIN, CMAX, CMIN, 0);
    send(3'd6, 24'sd1, -24'sd1, 24'sd1, -24'sd1, 0);
    send(3'd7, '0, '0, '0, 24'sd1, 0);
    send(3'd3, '0, '0, -24'sd1, CMAX, 0);
    send(3'd2, 24'sd3, -24'sd4, '0, '0, 0);
    send(3'd4, -24'sd1, '0, '0, '0, 0);
    send(3'd2, 24'sd1, 24'sd1, '0, '0, 0);
    send(3'd3, 24'sd4096, -24'sd4096, 24'sd4096, '0, 0);
    // hold off until the pipeline has drained completely
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < N_RANDOM; i++) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if ((i / 100) % 3 == 1) gap = 0;
      send(3'($urandom_range(0, 7)), rand_comp(), rand_comp(), rand_comp(),
           rand_comp(), gap);
    end
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("vector_normalize_unit test passed");
    else
      $display("vector_normalize_unit test failed");
    $finish;
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("vector_normalize_unit test failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
sv/vn_pkg.sv
sv/vn_if.sv
sv/vn_sqrt_cell.sv
sv/vn_div_cell.sv
sv/vector_normalize_unit.sv
tb/sv/vn_checker.sv
tb/sv/tb_vector_normalize_unit.sv
